/* sv/gas_event_detector_classifier_defines.svh */
// Assertion helpers for the gas event detector.
`ifndef GAS_EVENT_DETECTOR_CLASSIFIER_DEFINES_SVH
`define GAS_EVENT_DETECTOR_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define GEDC_ASSERT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gedc: assertion failed");

// Next-cycle implication, off while reset is asserted
`define GEDC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gedc: assertion failed");

`endif

/* sv/gedc_pkg.sv */
package gedc_pkg;

  // Field widths
  localparam int SAMPLE_BITS  = 16;
  localparam int TICK_BITS    = 16;
  localparam int CFG_BITS     = 16;
  localparam int FRAC_BITS    = 8;
  localparam int ACC_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int CLASS_BITS   = 2;
  localparam int CFG_IDX_BITS = 3;

  // Widths for exact compares
  localparam int DELTA_BITS = CFG_BITS + FRAC_BITS;
  localparam int SUM_BITS   = ((ACC_BITS > DELTA_BITS) ? ACC_BITS : DELTA_BITS) + 1;
  localparam int CMP_BITS   = (TICK_BITS > CFG_BITS) ? TICK_BITS : CFG_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TICK_BITS-1:0]   tick_t;
  typedef logic [ACC_BITS-1:0]    acc_t;
  typedef logic [CFG_BITS-1:0]    cfg_word_t;

  localparam tick_t TICK_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_EMA_ALPHA  = 3'd0,
    CFG_TRIGGER    = 3'd1,
    CFG_HYSTERESIS = 3'd2,
    CFG_END_TICKS  = 3'd3,
    CFG_FAST_PEAK  = 3'd4,
    CFG_COOLDOWN   = 3'd5,
    CFG_HIGH_PEAK  = 3'd6
  } cfg_idx_e;

  typedef enum logic [CLASS_BITS-1:0] {
    CLASS_NONE      = 2'd0,
    CLASS_FAST_HIGH = 2'd1,
    CLASS_SLOW_LOW  = 2'd2
  } class_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ACTIVE = 3'b010,
    PH_COOL   = 3'b100
  } phase_e;

  typedef struct packed {
    cfg_word_t ema_alpha;
    cfg_word_t trigger_delta;
    cfg_word_t hysteresis_delta;
    cfg_word_t end_ticks;
    cfg_word_t fast_peak_ticks;
    cfg_word_t cooldown_length;
    cfg_word_t high_peak_delta;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ema_alpha:        cfg_word_t'(3277),
    trigger_delta:    cfg_word_t'(160),
    hysteresis_delta: cfg_word_t'(80),
    end_ticks:        cfg_word_t'(3),
    fast_peak_ticks:  cfg_word_t'(5),
    cooldown_length:  cfg_word_t'(30),
    high_peak_delta:  cfg_word_t'(480)
  };

  typedef struct packed {
    class_e  event_class;
    sample_t base_level;
  } result_t;

  // Tick counters stick at all-ones
  function automatic tick_t sat_inc(tick_t v);
    return (v == TICK_MAX) ? v : v + tick_t'(1);
  endfunction

endpackage

/* sv/gedc_if.sv */
// Sample input channel
interface gedc_sample_if import gedc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_ppm;

  modport source (output valid, output sample_ppm, input ready);
  modport sink   (input valid, input sample_ppm, output ready);
endinterface

// Result output channel
interface gedc_result_if import gedc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CLASS_BITS-1:0] event_class;
  sample_t               base_level;

  modport source (output valid, output event_class, output base_level, input ready);
  modport sink   (input valid, input event_class, input base_level, output ready);
endinterface

// Register write channel
interface gedc_cfg_if import gedc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  cfg_word_t               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/gedc_cfg_regs.sv */
module gedc_cfg_regs import gedc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gedc_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always accepted; ready is tied high
  assign cfg_i.ready = 1'b1;

  // Decode register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_EMA_ALPHA:  cfg_d.ema_alpha        = cfg_i.data;
        CFG_TRIGGER:    cfg_d.trigger_delta    = cfg_i.data;
        CFG_HYSTERESIS: cfg_d.hysteresis_delta = cfg_i.data;
        CFG_END_TICKS:  cfg_d.end_ticks        = cfg_i.data;
        CFG_FAST_PEAK:  cfg_d.fast_peak_ticks  = cfg_i.data;
        CFG_COOLDOWN:   cfg_d.cooldown_length  = cfg_i.data;
        CFG_HIGH_PEAK:  cfg_d.high_peak_delta  = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/gedc_core.sv */
`include "gas_event_detector_classifier_defines.svh"

module gedc_core import gedc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic    primed_q, primed_d;
  phase_e  phase_q, phase_d;
  acc_t    base_q, base_d;
  sample_t peak_q, peak_d;
  tick_t   ev_tick_q, ev_tick_d;
  tick_t   pk_tick_q, pk_tick_d;
  tick_t   near_q, near_d;
  tick_t   cool_q, cool_d;
  class_e  held_q, held_d;

  acc_t                  s12;
  logic                  d_pos;
  acc_t                  d_mag;
  logic [ACC_BITS+CFG_BITS-1:0] prod;
  acc_t                  ema_step;
  acc_t                  base_ema;
  logic [SUM_BITS-1:0]   trig_thr;
  logic [SUM_BITS-1:0]   near_thr;
  logic [SUM_BITS-1:0]   high_thr;
  tick_t                 ev_inc;
  tick_t                 near_nxt;
  tick_t                 cool_inc;
  logic                  pk_upd;
  sample_t               peak_nxt;
  tick_t                 pk_tick_nxt;
  logic                  fast;
  logic                  high;

  assign s12 = {sample_i, FRAC_BITS'(0)};

  // EMA step, truncated toward zero
  assign d_pos    = (s12 >= base_q);
  assign d_mag    = d_pos ? (s12 - base_q) : (base_q - s12);
  assign prod     = cfg_i.ema_alpha * d_mag;
  assign ema_step = prod[ACC_BITS+CFG_BITS-1:CFG_BITS];
  assign base_ema = d_pos ? (base_q + ema_step) : (base_q - ema_step);

  // Thresholds in Q16.8
  assign trig_thr = SUM_BITS'(base_ema) + SUM_BITS'({cfg_i.trigger_delta, FRAC_BITS'(0)});
  assign near_thr = SUM_BITS'(base_q) + SUM_BITS'({cfg_i.hysteresis_delta, FRAC_BITS'(0)});
  assign high_thr = SUM_BITS'(base_q) + SUM_BITS'({cfg_i.high_peak_delta, FRAC_BITS'(0)});

  assign ev_inc   = sat_inc(ev_tick_q);
  assign near_nxt = (SUM_BITS'(s12) < near_thr) ? sat_inc(near_q) : '0;
  assign cool_inc = sat_inc(cool_q);

  // Peak tracking for an active sample
  assign pk_upd      = (sample_i > peak_q);
  assign peak_nxt    = pk_upd ? sample_i : peak_q;
  assign pk_tick_nxt = pk_upd ? ev_inc : pk_tick_q;

  // Classification uses the peak as updated by this sample
  assign fast = CMP_BITS'(pk_tick_nxt) <= CMP_BITS'(cfg_i.fast_peak_ticks);
  assign high = SUM_BITS'({peak_nxt, FRAC_BITS'(0)}) > high_thr;

  // Next state for one sample
  always_comb begin
    primed_d  = primed_q;
    phase_d   = phase_q;
    base_d    = base_q;
    peak_d    = peak_q;
    ev_tick_d = ev_tick_q;
    pk_tick_d = pk_tick_q;
    near_d    = near_q;
    cool_d    = cool_q;
    held_d    = held_q;
    if (step_i) begin
      if (!primed_q) begin
        base_d   = s12;
        primed_d = 1'b1;
      end else begin
        unique case (phase_q)
          PH_ACTIVE: begin
            ev_tick_d = ev_inc;
            peak_d    = peak_nxt;
            pk_tick_d = pk_tick_nxt;
            near_d    = near_nxt;
            if (CMP_BITS'(near_nxt) >= CMP_BITS'(cfg_i.end_ticks)) begin
              held_d  = (fast || high) ? CLASS_FAST_HIGH : CLASS_SLOW_LOW;
              phase_d = PH_COOL;
              cool_d  = '0;
            end
          end
          PH_COOL: begin
            cool_d = cool_inc;
            if (CMP_BITS'(cool_inc) >= CMP_BITS'(cfg_i.cooldown_length)) begin
              phase_d = PH_IDLE;
              held_d  = CLASS_NONE;
            end
          end
          default: begin
            // idle, and any stray code
            phase_d = PH_IDLE;
            base_d  = base_ema;
            if (SUM_BITS'(s12) > trig_thr) begin
              phase_d   = PH_ACTIVE;
              peak_d    = sample_i;
              ev_tick_d = tick_t'(1);
              pk_tick_d = tick_t'(1);
              near_d    = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q  <= 1'b0;
      phase_q   <= PH_IDLE;
      base_q    <= '0;
      peak_q    <= '0;
      ev_tick_q <= '0;
      pk_tick_q <= '0;
      near_q    <= '0;
      cool_q    <= '0;
      held_q    <= CLASS_NONE;
    end else begin
      primed_q  <= primed_d;
      phase_q   <= phase_d;
      base_q    <= base_d;
      peak_q    <= peak_d;
      ev_tick_q <= ev_tick_d;
      pk_tick_q <= pk_tick_d;
      near_q    <= near_d;
      cool_q    <= cool_d;
      held_q    <= held_d;
    end
  end

  // Result word for the sample being stepped
  assign res_o.event_class = held_d;
  assign res_o.base_level  = base_d[ACC_BITS-1:FRAC_BITS];

  // A class is only held during cooldown
  `GEDC_ASSERT(a_class_in_cool, clk_i, rst_ni, held_q != CLASS_NONE, phase_q == PH_COOL)
  // Peak never lies after the current event tick
  `GEDC_ASSERT(a_peak_tick_order, clk_i, rst_ni, phase_q == PH_ACTIVE, pk_tick_q <= ev_tick_q)
  // First sample loads the baseline directly
  `GEDC_ASSERT_NEXT(a_prime_load, clk_i, rst_ni, step_i && !primed_q,
                    base_q == $past(s12) && primed_q)
  // Idle never jumps straight to cooldown
  `GEDC_ASSERT_NEXT(a_idle_no_cool, clk_i, rst_ni, step_i && phase_q == PH_IDLE,
                    phase_q != PH_COOL)

endmodule

/* sv/gas_event_detector_classifier.sv */
// Path: a sample word accepted into the input register is stepped through the detector
// core, and its result word is written to the result register when that register is free.
// Throughput: one sample word per cycle while the result channel is ready; the detector
// state is updated combinationally between the input register and the result register.
// Reset (rst_ni low, asynchronous): configuration registers return to their defaults,
// valid flags and detector state are cleared and the next sample only primes the baseline.
module gas_event_detector_classifier import gedc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  gedc_cfg_if.sink      cfg_i,
  gedc_sample_if.sink   sample_i,
  gedc_result_if.source result_o
);

  cfg_t    cfg;
  result_t core_res;

  logic    in_valid_q, in_valid_d;
  sample_t in_sample_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  logic    advance;
  logic    in_take;

  gedc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake: input stage moves on when the result register is free
  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !in_valid_q || advance;
  assign in_take        = sample_i.valid && sample_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  gedc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_sample_q),
    .cfg_i    (cfg),
    .res_o    (core_res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= sample_i.sample_ppm;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.event_class = out_res_q.event_class;
  assign result_o.base_level  = out_res_q.base_level;

endmodule
